>>> hdl/plist_pkg.sv
`default_nettype none

package plist_pkg;

	localparam int OP_W     = 3;
	localparam int POS_W    = 7;
	localparam int DATA_W   = 32;
	localparam int STATUS_W = 2;

	typedef enum logic [OP_W-1:0] {
		OP_GET    = 3'd0,
		OP_CHANGE = 3'd1,
		OP_INSERT = 3'd2,
		OP_DELETE = 3'd3,
		OP_LOCATE = 3'd4,
		OP_PRIOR  = 3'd5,
		OP_NEXT   = 3'd6,
		OP_CLEAR  = 3'd7
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK   = 2'd0,
		ST_BAD  = 2'd1,
		ST_FULL = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_WALK,
		S_PUT,
		S_DONE
	} state_t;

endpackage

`default_nettype wire

>>> hdl/plist_if.sv
`default_nettype none

interface plist_req_if;
	logic                        valid;
	logic                        ready;
	logic [plist_pkg::OP_W-1:0]  op;
	logic [plist_pkg::POS_W-1:0] position;
	logic [plist_pkg::DATA_W-1:0] value;

	modport source (output valid, output op, output position, output value, input ready);
	modport sink   (input valid, input op, input position, input value, output ready);
endinterface

interface plist_rsp_if;
	logic                           valid;
	logic                           ready;
	logic [plist_pkg::STATUS_W-1:0] status;
	logic [plist_pkg::DATA_W-1:0]   data;
	logic [plist_pkg::POS_W-1:0]    found_position;
	logic [plist_pkg::POS_W-1:0]    list_length;
	logic                           is_empty;

	modport source (output valid, output status, output data, output found_position,
		output list_length, output is_empty, input ready);
	modport sink   (input valid, input status, input data, input found_position,
		input list_length, input is_empty, output ready);
endinterface

`default_nettype wire

>>> hdl/positional_list_engine_core.sv
// Change, append, clear and rejected requests go straight to the result; get, delete
// and searches first walk the store, and a shifting insert walks it and then writes the
// new element in S_PUT. Elements read: 1 for get, count - position + 1 for insert and
// delete, up to count for locate, prior and next. One element passes the store per cycle.
// Requests are handled one at a time; a new one is taken once the result is registered.
// Reset clears the length, state, read valids, hit flag and response valid, not the store.
`default_nettype none

module positional_list_engine_core #(
	parameter int CAPACITY      = 64,
	parameter int ELEMENT_WIDTH = 32
) (
	input wire logic      clk,
	input wire logic      arst_n,
	plist_req_if.sink     req,
	plist_rsp_if.source   rsp
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int LW = ((CW > plist_pkg::POS_W) ? CW : plist_pkg::POS_W) + 1;
	localparam int EW = ELEMENT_WIDTH;
	localparam int DW = plist_pkg::DATA_W;

	plist_pkg::state_t  state_q, state_d;
	plist_pkg::op_t     op_q, op_d;
	plist_pkg::status_t wst_q, wst_d;

	logic [AW-1:0] pos0_q, pos0_d;
	logic [EW-1:0] val_q, val_d;
	logic [CW-1:0] count_q, count_d;
	logic          iss_q, iss_d;
	logic [AW-1:0] rd_addr_q, rd_addr_d;
	logic [AW-1:0] end_q, end_d;
	logic          vld_s1, vld_d;
	logic [AW-1:0] addr_s1, addr_s1_d;
	logic          hit_q, hit_d;
	logic [EW-1:0] prev_q, prev_d;
	logic [EW-1:0] wdat_q, wdat_d;
	logic [plist_pkg::POS_W-1:0] wfnd_q, wfnd_d;

	logic                           rsp_valid_q;
	logic [plist_pkg::STATUS_W-1:0] rsp_status_q;
	logic [DW-1:0]                  rsp_data_q;
	logic [plist_pkg::POS_W-1:0]    rsp_found_q;
	logic [plist_pkg::POS_W-1:0]    rsp_len_q;
	logic                           rsp_empty_q;

	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [EW-1:0] ram_wdata;
	logic [EW-1:0] ram_rdata;
	logic          load_out;
	logic          finish;

	logic [LW-1:0] pos_ext, cnt_ext, fnd_ext;
	logic [AW-1:0] p0_in, last_idx;
	logic [EW-1:0] val_in;
	logic          pos_ok, ins_ok, s1_end, match;

	plist_ram #(
		.WIDTH (EW),
		.DEPTH (CAPACITY)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (rd_addr_q),
		.rdata (ram_rdata)
	);

	assign pos_ext  = LW'(req.position);
	assign cnt_ext  = LW'(count_q);
	assign pos_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
	assign ins_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext + 1'b1);
	assign p0_in    = AW'(pos_ext - 1'b1);
	assign last_idx = AW'(count_q - 1'b1);
	assign val_in   = EW'(req.value);
	assign s1_end   = (addr_s1 == end_q);
	assign match    = (ram_rdata == val_q);
	assign fnd_ext  = LW'(addr_s1) + 1'b1;

	assign req.ready = (state_q == plist_pkg::S_IDLE);

	always_comb begin
		state_d   = state_q;
		op_d      = op_q;
		pos0_d    = pos0_q;
		val_d     = val_q;
		count_d   = count_q;
		iss_d     = iss_q;
		rd_addr_d = rd_addr_q;
		end_d     = end_q;
		vld_d     = 1'b0;
		addr_s1_d = rd_addr_q;
		hit_d     = hit_q;
		prev_d    = prev_q;
		wst_d     = wst_q;
		wdat_d    = wdat_q;
		wfnd_d    = wfnd_q;
		ram_we    = 1'b0;
		ram_waddr = pos0_q;
		ram_wdata = val_q;
		load_out  = 1'b0;
		finish    = 1'b0;

		case (state_q)
			plist_pkg::S_IDLE: begin
				if (req.valid) begin
					op_d    = plist_pkg::op_t'(req.op);
					pos0_d  = p0_in;
					val_d   = val_in;
					hit_d   = 1'b0;
					wst_d   = plist_pkg::ST_BAD;
					wdat_d  = '0;
					wfnd_d  = '0;
					state_d = plist_pkg::S_DONE;
					case (plist_pkg::op_t'(req.op))
						plist_pkg::OP_GET: begin
							if (pos_ok) begin
								iss_d     = 1'b1;
								rd_addr_d = p0_in;
								end_d     = p0_in;
								state_d   = plist_pkg::S_WALK;
							end
						end
						plist_pkg::OP_CHANGE: begin
							if (pos_ok) begin
								ram_we    = 1'b1;
								ram_waddr = p0_in;
								ram_wdata = val_in;
								wst_d     = plist_pkg::ST_OK;
							end
						end
						plist_pkg::OP_INSERT: begin
							if (ins_ok) begin
								if (count_q == CW'(CAPACITY)) begin
									wst_d = plist_pkg::ST_FULL;
								end else if (pos_ext == cnt_ext + 1'b1) begin
									// append: nothing to shift
									ram_we    = 1'b1;
									ram_waddr = p0_in;
									ram_wdata = val_in;
									count_d   = count_q + 1'b1;
									wst_d     = plist_pkg::ST_OK;
								end else begin
									iss_d     = 1'b1;
									rd_addr_d = last_idx;
									end_d     = p0_in;
									state_d   = plist_pkg::S_WALK;
								end
							end
						end
						plist_pkg::OP_DELETE: begin
							if (pos_ok) begin
								iss_d     = 1'b1;
								rd_addr_d = p0_in;
								end_d     = last_idx;
								state_d   = plist_pkg::S_WALK;
							end
						end
						plist_pkg::OP_LOCATE, plist_pkg::OP_PRIOR, plist_pkg::OP_NEXT: begin
							if (count_q != '0) begin
								iss_d     = 1'b1;
								rd_addr_d = '0;
								end_d     = last_idx;
								state_d   = plist_pkg::S_WALK;
							end
						end
						plist_pkg::OP_CLEAR: begin
							count_d = '0;
							wst_d   = plist_pkg::ST_OK;
						end
						default: begin
							state_d = plist_pkg::S_DONE;
						end
					endcase
				end
			end

			plist_pkg::S_WALK: begin
				// issue side runs one read ahead of the compare/write side
				if (iss_q) begin
					vld_d = 1'b1;
					if (rd_addr_q == end_q) begin
						iss_d = 1'b0;
					end else if (op_q == plist_pkg::OP_INSERT) begin
						rd_addr_d = rd_addr_q - 1'b1;
					end else begin
						rd_addr_d = rd_addr_q + 1'b1;
					end
				end
				if (vld_s1) begin
					case (op_q)
						plist_pkg::OP_GET: begin
							wdat_d = ram_rdata;
							wst_d  = plist_pkg::ST_OK;
							finish = 1'b1;
						end
						plist_pkg::OP_INSERT: begin
							ram_we    = 1'b1;
							ram_waddr = addr_s1 + 1'b1;
							ram_wdata = ram_rdata;
							if (s1_end) begin
								state_d = plist_pkg::S_PUT;
							end
						end
						plist_pkg::OP_DELETE: begin
							if (addr_s1 == pos0_q) begin
								wdat_d = ram_rdata;
							end else begin
								ram_we    = 1'b1;
								ram_waddr = addr_s1 - 1'b1;
								ram_wdata = ram_rdata;
							end
							if (s1_end) begin
								count_d = count_q - 1'b1;
								wst_d   = plist_pkg::ST_OK;
								finish  = 1'b1;
							end
						end
						plist_pkg::OP_LOCATE: begin
							if (match) begin
								wfnd_d = fnd_ext[plist_pkg::POS_W-1:0];
								wst_d  = plist_pkg::ST_OK;
								finish = 1'b1;
							end else if (s1_end) begin
								finish = 1'b1;
							end
						end
						plist_pkg::OP_PRIOR: begin
							prev_d = ram_rdata;
							if (addr_s1 != '0 && match) begin
								wdat_d = prev_q;
								wst_d  = plist_pkg::ST_OK;
								finish = 1'b1;
							end else if (s1_end) begin
								finish = 1'b1;
							end
						end
						plist_pkg::OP_NEXT: begin
							// after a match the following element is already in flight
							if (hit_q) begin
								wdat_d = ram_rdata;
								wst_d  = plist_pkg::ST_OK;
								finish = 1'b1;
							end else if (match && !s1_end) begin
								hit_d = 1'b1;
							end else if (s1_end) begin
								finish = 1'b1;
							end
						end
						default: begin
							finish = 1'b1;
						end
					endcase
				end
				if (finish) begin
					// drop any read still in flight
					state_d = plist_pkg::S_DONE;
					iss_d   = 1'b0;
					vld_d   = 1'b0;
				end
			end

			plist_pkg::S_PUT: begin
				ram_we    = 1'b1;
				ram_waddr = pos0_q;
				ram_wdata = val_q;
				count_d   = count_q + 1'b1;
				wst_d     = plist_pkg::ST_OK;
				state_d   = plist_pkg::S_DONE;
			end

			plist_pkg::S_DONE: begin
				if (!rsp_valid_q || rsp.ready) begin
					load_out = 1'b1;
					state_d  = plist_pkg::S_IDLE;
				end
			end

			default: begin
				state_d = plist_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= plist_pkg::S_IDLE;
			count_q     <= '0;
			iss_q       <= 1'b0;
			vld_s1      <= 1'b0;
			hit_q       <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			count_q <= count_d;
			iss_q   <= iss_d;
			vld_s1  <= vld_d;
			hit_q   <= hit_d;
			if (load_out) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		op_q      <= op_d;
		pos0_q    <= pos0_d;
		val_q     <= val_d;
		rd_addr_q <= rd_addr_d;
		end_q     <= end_d;
		addr_s1   <= addr_s1_d;
		prev_q    <= prev_d;
		wst_q     <= wst_d;
		wdat_q    <= wdat_d;
		wfnd_q    <= wfnd_d;
		if (load_out) begin
			rsp_status_q <= wst_q;
			rsp_data_q   <= DW'(wdat_q);
			rsp_found_q  <= wfnd_q;
			rsp_len_q    <= cnt_ext[plist_pkg::POS_W-1:0];
			rsp_empty_q  <= (count_q == '0);
		end
	end

	assign rsp.valid          = rsp_valid_q;
	assign rsp.status         = rsp_status_q;
	assign rsp.data           = rsp_data_q;
	assign rsp.found_position = rsp_found_q;
	assign rsp.list_length    = rsp_len_q;
	assign rsp.is_empty       = rsp_empty_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(CAPACITY))
		else $error("list length exceeds capacity");

	a_write_in_list: assert property (@(posedge clk) disable iff (!arst_n)
		ram_we |-> (LW'(ram_waddr) <= cnt_ext))
		else $error("store write beyond the end of the list");

	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == plist_pkg::S_IDLE) |-> (!iss_q && !vld_s1))
		else $error("read pipeline busy while taking a new transaction");

	a_put_after_walk: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == plist_pkg::S_PUT) |-> $past(state_q == plist_pkg::S_WALK)
		&& op_q == plist_pkg::OP_INSERT)
		else $error("insert write without a preceding shift");
`endif

endmodule

`default_nettype wire

>>> hdl/plist_ram.sv
`default_nettype none

module plist_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire
